### hdl/swtmr_pkg.sv
// Shared types and constants for the software timer slot table.
package swtmr_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int TICK_WIDTH_DEF = 16;

  // At most this many slots fire on one dispatch
  localparam int RESULT_CAP = 8;
  localparam int FIRE_W     = $clog2(RESULT_CAP + 1);

  localparam int OP_W       = 3;
  localparam int SLOT_W     = 3;
  localparam int TICK_IN_W  = 16;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 3'd0,
    OP_TICK     = 3'd1,
    OP_DISPATCH = 3'd2,
    OP_DELAY    = 3'd3,
    OP_SLEEP    = 3'd4,
    OP_WAKEUP   = 3'd5,
    OP_DELETE   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_READY = 2'd2,
    MODE_SLEEP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic run;
    logic emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic fired_any;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/swtmr_ctrl.sv
// Sequencer for the timer table: accept, slot sweep, closing result.
module swtmr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  swtmr_pkg::dp_sts_t  sts_i,
  output swtmr_pkg::dp_cmd_t  cmd_o
);

  swtmr_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swtmr_pkg::ST_IDLE: begin
        if (s_tvalid_i) state_d = swtmr_pkg::ST_SWEEP;
      end
      swtmr_pkg::ST_SWEEP: begin
        // a dispatch that fired has already loaded its last beat into the result register
        if (sts_i.done) begin
          state_d = sts_i.fired_any ? swtmr_pkg::ST_IDLE : swtmr_pkg::ST_RESULT;
        end
      end
      swtmr_pkg::ST_RESULT: begin
        if (sts_i.out_free) state_d = swtmr_pkg::ST_IDLE;
      end
      default: state_d = swtmr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o       = 1'b0;
    cmd_o.start      = 1'b0;
    cmd_o.run        = 1'b0;
    cmd_o.emit_final = 1'b0;
    unique case (state_q)
      swtmr_pkg::ST_IDLE: begin
        s_tready_o  = 1'b1;
        cmd_o.start = s_tvalid_i;
      end
      swtmr_pkg::ST_SWEEP:  cmd_o.run = 1'b1;
      swtmr_pkg::ST_RESULT: cmd_o.emit_final = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swtmr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/swtmr_dp.sv
// Timer table datapath: slot modes, tick and period memories, sweep pipe, result register.
module swtmr_dp #(
  parameter int SLOTS      = swtmr_pkg::SLOTS_DEF,
  parameter int TICK_WIDTH = swtmr_pkg::TICK_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swtmr_pkg::dp_cmd_t            cmd_i,
  output swtmr_pkg::dp_sts_t            sts_o,
  input  logic [swtmr_pkg::OP_W-1:0]    op_i,
  input  logic [swtmr_pkg::SLOT_W-1:0]  idx_i,
  input  logic [TICK_WIDTH-1:0]         ticks_i,
  input  logic [TICK_WIDTH-1:0]         reload_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic                          m_status_o,
  output logic [swtmr_pkg::SLOT_W-1:0]  m_slot_o,
  output logic                          m_fired_o,
  output logic                          m_last_o
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (IW > swtmr_pkg::SLOT_W) ? IW : swtmr_pkg::SLOT_W;

  // item registers
  swtmr_pkg::op_e                op_q;
  logic [swtmr_pkg::SLOT_W-1:0]  idx_q;
  logic [TICK_WIDTH-1:0]         ticks_q;
  logic [TICK_WIDTH-1:0]         reload_q;

  // table
  swtmr_pkg::mode_e              mode_q [SLOTS];
  logic [TICK_WIDTH-1:0]         tick_mem [SLOTS];
  logic [TICK_WIDTH-1:0]         period_mem [SLOTS];
  logic [TICK_WIDTH-1:0]         tick_rd_q;
  logic [TICK_WIDTH-1:0]         period_rd_q;

  // sweep
  logic [CW-1:0]                 iss_q;
  logic                          proc_vld_q;
  logic [IW-1:0]                 proc_ptr_q;
  logic [swtmr_pkg::FIRE_W-1:0]  fire_cnt_q;
  logic                          found_q;
  logic                          err_q;
  logic [IW-1:0]                 res_slot_q;

  // result register
  logic                          out_vld_q;
  logic                          out_status_q;
  logic [swtmr_pkg::SLOT_W-1:0]  out_slot_q;
  logic                          out_fired_q;
  logic                          out_last_q;

  swtmr_pkg::mode_e              cur_mode;
  swtmr_pkg::mode_e              mode_new;
  logic                          issue;
  logic                          hit;
  logic [TICK_WIDTH-1:0]         dec_tick;
  logic [TICK_WIDTH-1:0]         tick_new;
  logic [SLOTS-1:0]              ready_above;
  logic                          fire_ok;
  logic                          need_emit;
  logic                          last_fire;
  logic                          out_free;
  logic                          adv;
  logic                          exec;
  logic                          mode_wr;
  logic                          tick_wr;
  logic                          period_wr;
  logic                          err_set;
  logic                          found_set;
  logic                          err_init;
  logic                          load_fire;
  logic                          load_final;

  always_comb begin
    unique case (swtmr_pkg::op_e'(op_i))
      swtmr_pkg::OP_REGISTER: err_init = 1'b1;  // cleared once a free slot is taken
      swtmr_pkg::OP_TICK,
      swtmr_pkg::OP_DISPATCH: err_init = 1'b0;
      swtmr_pkg::OP_DELAY,
      swtmr_pkg::OP_SLEEP,
      swtmr_pkg::OP_WAKEUP,
      swtmr_pkg::OP_DELETE:   err_init = (int'(idx_i) >= SLOTS);
      default:                err_init = 1'b1;
    endcase
  end

  always_comb begin
    cur_mode  = mode_q[proc_ptr_q];
    issue     = (iss_q < CW'(SLOTS));
    hit       = (CMPW'(proc_ptr_q) == CMPW'(idx_q));
    dec_tick  = (tick_rd_q == '0) ? '0 : tick_rd_q - TICK_WIDTH'(1);
    for (int k = 0; k < SLOTS; k++) begin
      ready_above[k] = (mode_q[k] == swtmr_pkg::MODE_READY) && (IW'(k) > proc_ptr_q);
    end
    fire_ok   = (fire_cnt_q < swtmr_pkg::FIRE_W'(swtmr_pkg::RESULT_CAP));
    need_emit = proc_vld_q && (op_q == swtmr_pkg::OP_DISPATCH) &&
                (cur_mode == swtmr_pkg::MODE_READY) && fire_ok;
    last_fire = (fire_cnt_q == swtmr_pkg::FIRE_W'(swtmr_pkg::RESULT_CAP - 1)) ||
                !(|ready_above);
    out_free  = !out_vld_q || m_tready_i;
    // the pipe holds while a fired beat cannot get into the result register
    adv       = cmd_i.run && !(need_emit && !out_free);
    exec      = adv && proc_vld_q;
  end

  always_comb begin
    mode_wr   = 1'b0;
    mode_new  = cur_mode;
    tick_wr   = 1'b0;
    tick_new  = ticks_q;
    period_wr = 1'b0;
    err_set   = 1'b0;
    found_set = 1'b0;
    if (exec) begin
      unique case (op_q)
        swtmr_pkg::OP_REGISTER: begin
          if (!found_q && (cur_mode == swtmr_pkg::MODE_FREE)) begin
            mode_wr   = 1'b1;
            mode_new  = swtmr_pkg::MODE_WAIT;
            tick_wr   = 1'b1;
            period_wr = 1'b1;
            found_set = 1'b1;
          end
        end
        swtmr_pkg::OP_TICK: begin
          if (cur_mode == swtmr_pkg::MODE_WAIT) begin
            tick_wr  = 1'b1;
            tick_new = dec_tick;
            if (dec_tick == '0) begin
              mode_wr  = 1'b1;
              mode_new = swtmr_pkg::MODE_READY;
            end
          end
        end
        swtmr_pkg::OP_DISPATCH: begin
          if (need_emit) begin
            mode_wr = 1'b1;
            if (period_rd_q != '0) begin
              tick_wr  = 1'b1;
              tick_new = period_rd_q;
              mode_new = swtmr_pkg::MODE_WAIT;
            end else begin
              mode_new = swtmr_pkg::MODE_FREE;
            end
          end
        end
        swtmr_pkg::OP_DELAY: begin
          if (hit) begin
            if (cur_mode == swtmr_pkg::MODE_FREE) begin
              err_set = 1'b1;
            end else begin
              tick_wr  = 1'b1;
              mode_wr  = 1'b1;
              mode_new = swtmr_pkg::MODE_WAIT;
            end
          end
        end
        swtmr_pkg::OP_SLEEP: begin
          if (hit) begin
            if ((cur_mode == swtmr_pkg::MODE_FREE) || (cur_mode == swtmr_pkg::MODE_SLEEP)) begin
              err_set = 1'b1;
            end else begin
              mode_wr  = 1'b1;
              mode_new = swtmr_pkg::MODE_SLEEP;
            end
          end
        end
        swtmr_pkg::OP_WAKEUP: begin
          if (hit) begin
            if (cur_mode != swtmr_pkg::MODE_SLEEP) begin
              err_set = 1'b1;
            end else begin
              mode_wr  = 1'b1;
              mode_new = swtmr_pkg::MODE_READY;
            end
          end
        end
        swtmr_pkg::OP_DELETE: begin
          if (hit) begin
            if (cur_mode == swtmr_pkg::MODE_FREE) begin
              err_set = 1'b1;
            end else begin
              mode_wr  = 1'b1;
              mode_new = swtmr_pkg::MODE_FREE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign load_fire  = exec && need_emit;
  assign load_final = cmd_i.emit_final && out_free;

  assign sts_o.done      = (iss_q == CW'(SLOTS)) && (!proc_vld_q || adv);
  assign sts_o.fired_any = (fire_cnt_q != '0) || load_fire;
  assign sts_o.out_free  = out_free;

  // tick and period stores: ticks and period of a free slot are never used,
  // so they carry no reset
  always_ff @(posedge clk_i) begin
    if (tick_wr)   tick_mem[proc_ptr_q]   <= tick_new;
    if (period_wr) period_mem[proc_ptr_q] <= reload_q;
    if (adv && issue) begin
      tick_rd_q   <= tick_mem[iss_q[IW-1:0]];
      period_rd_q <= period_mem[iss_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q       <= swtmr_pkg::op_e'(op_i);
      idx_q      <= idx_i;
      ticks_q    <= ticks_i;
      reload_q   <= reload_i;
      res_slot_q <= '0;
    end else if (found_set) begin
      res_slot_q <= proc_ptr_q;
    end
    if (adv && issue) proc_ptr_q <= iss_q[IW-1:0];
    if (load_fire || load_final) begin
      out_status_q <= load_fire ? 1'b0 : err_q;
      out_slot_q   <= load_fire ? swtmr_pkg::SLOT_W'(proc_ptr_q)
                                : swtmr_pkg::SLOT_W'(res_slot_q);
      out_fired_q  <= load_fire;
      out_last_q   <= load_fire ? last_fire : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) mode_q[k] <= swtmr_pkg::MODE_FREE;
      iss_q      <= CW'(SLOTS);
      proc_vld_q <= 1'b0;
      fire_cnt_q <= '0;
      found_q    <= 1'b0;
      err_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (mode_wr) mode_q[proc_ptr_q] <= mode_new;
      if (cmd_i.start) begin
        iss_q      <= '0;
        proc_vld_q <= 1'b0;
        fire_cnt_q <= '0;
        found_q    <= 1'b0;
        err_q      <= err_init;
      end else begin
        if (adv) begin
          proc_vld_q <= issue;
          if (issue) iss_q <= iss_q + CW'(1);
        end
        if (load_fire) fire_cnt_q <= fire_cnt_q + swtmr_pkg::FIRE_W'(1);
        if (found_set) begin
          found_q <= 1'b1;
          err_q   <= 1'b0;
        end else if (err_set) begin
          err_q <= 1'b1;
        end
      end
      if (load_fire || load_final) out_vld_q <= 1'b1;
      else if (m_tready_i)         out_vld_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_status_o = out_status_q;
  assign m_slot_o   = out_slot_q;
  assign m_fired_o  = out_fired_q;
  assign m_last_o   = out_last_q;

endmodule

### hdl/software_timer_task_table.sv
// Software timer slot table: register, tick, dispatch, delay, sleep, wake-up and delete
// operations on SLOTS timer slots. One operation is taken at a time; each one sweeps the
// slot memories one slot per cycle while no fired result beat waits on the output side,
// and the block takes no new beat until the sweep has finished and its last result beat
// has been loaded into the result register.
// Every operation answers with one result beat, except a dispatch that fires slots: it
// sends one beat per fired slot in slot order, at most eight, the last with tlast set.
module software_timer_task_table #(
  parameter int SLOTS      = swtmr_pkg::SLOTS_DEF,
  parameter int TICK_WIDTH = swtmr_pkg::TICK_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // slot_index [2:0], tick_count [18:3], reload_value [34:19], zero fill
  input  logic [swtmr_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // operation [2:0]
  input  logic [swtmr_pkg::OP_W-1:0]         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status [0], result_slot [3:1], zero fill
  output logic [swtmr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // fired [0]
  output logic [0:0]                         m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  swtmr_pkg::dp_cmd_t            cmd;
  swtmr_pkg::dp_sts_t            sts;
  logic                          out_status;
  logic [swtmr_pkg::SLOT_W-1:0]  out_slot;
  logic                          out_fired;

  swtmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swtmr_dp #(
    .SLOTS      (SLOTS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (s_axis_tuser_i),
    .idx_i      (s_axis_tdata_i[2:0]),
    .ticks_i    (TICK_WIDTH'(s_axis_tdata_i[18:3])),
    .reload_i   (TICK_WIDTH'(s_axis_tdata_i[34:19])),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_status_o (out_status),
    .m_slot_o   (out_slot),
    .m_fired_o  (out_fired),
    .m_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, out_slot, out_status};
  assign m_axis_tuser_o = out_fired;

  // an accepted beat always starts a sweep, so the input closes next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input still open after accepting a beat");

  // a fired slot beat never reports an error
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tdata_o[0])
    else $error("fired beat carries error status");

  // beats that name no fired slot are always the closing beat of their operation
  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("non-fired beat without tlast");

  // the closing result is only loaded once the sweep has finished
  a_final_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_final |-> !cmd.run && !cmd.start)
    else $error("closing result requested during a sweep");

endmodule

### sim/software_timer_task_table_tb.sv
// Self-checking testbench for the software timer slot table stream block.
`timescale 1ns / 100ps

module software_timer_task_table_tb;

  localparam int SLOTS       = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 100;
  // operation code the block must reject
  localparam logic [swtmr_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic       status;
    logic [2:0] slot;
    logic       fired;
    logic       last;
  } timer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [swtmr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [swtmr_pkg::OP_W-1:0]        s_axis_tuser_i = '0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [swtmr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [0:0]                        m_axis_tuser_o;
  logic                              m_axis_tlast_o;

  // model of the slot table
  swtmr_pkg::mode_e slot_mode_q [SLOTS];
  logic [15:0]      slot_ticks_q [SLOTS];
  logic [15:0]      slot_period_q [SLOTS];

  timer_result_t expected_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  software_timer_task_table #(
    .SLOTS(SLOTS),
    .TICK_WIDTH(16)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o),
    .m_axis_tlast_o(m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic void push_result(logic status, logic [2:0] slot, logic fired,
                                      logic last);
    timer_result_t r;
    r.status = status;
    r.slot   = slot;
    r.fired  = fired;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  function automatic void reset_slot_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_mode_q[i]   = swtmr_pkg::MODE_FREE;
      slot_ticks_q[i]  = '0;
      slot_period_q[i] = '0;
    end
  endfunction

  // Applies one operation to the table copy and queues the beats it produces
  function automatic void predict_timer_op(logic [swtmr_pkg::OP_W-1:0] op, logic [2:0] idx,
                                           logic [15:0] ticks, logic [15:0] reload);
    int   fired_slots[$];
    logic err;
    logic [2:0] slot_out;
    err = 1'b0;
    slot_out = '0;
    case (op)
      swtmr_pkg::OP_REGISTER: begin
        err = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (err && slot_mode_q[i] == swtmr_pkg::MODE_FREE) begin
            slot_mode_q[i]   = swtmr_pkg::MODE_WAIT;
            slot_ticks_q[i]  = ticks;
            slot_period_q[i] = reload;
            slot_out = i[2:0];
            err = 1'b0;
          end
        end
      end
      swtmr_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_mode_q[i] == swtmr_pkg::MODE_WAIT) begin
            if (slot_ticks_q[i] != 0) slot_ticks_q[i] = slot_ticks_q[i] - 1'b1;
            if (slot_ticks_q[i] == 0) slot_mode_q[i] = swtmr_pkg::MODE_READY;
          end
        end
      end
      swtmr_pkg::OP_DISPATCH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_mode_q[i] == swtmr_pkg::MODE_READY &&
              fired_slots.size() < swtmr_pkg::RESULT_CAP) begin
            fired_slots.push_back(i);
            if (slot_period_q[i] != 0) begin
              slot_ticks_q[i] = slot_period_q[i];
              slot_mode_q[i]  = swtmr_pkg::MODE_WAIT;
            end else begin
              slot_mode_q[i]   = swtmr_pkg::MODE_FREE;
              slot_ticks_q[i]  = '0;
              slot_period_q[i] = '0;
            end
          end
        end
        if (fired_slots.size() == 0) begin
          push_result(1'b0, 3'd0, 1'b0, 1'b1);
        end else begin
          foreach (fired_slots[k])
            push_result(1'b0, fired_slots[k][2:0], 1'b1, k == fired_slots.size() - 1);
        end
        return;
      end
      swtmr_pkg::OP_DELAY: begin
        if (slot_mode_q[idx] == swtmr_pkg::MODE_FREE) begin
          err = 1'b1;
        end else begin
          slot_ticks_q[idx] = ticks;
          slot_mode_q[idx]  = swtmr_pkg::MODE_WAIT;
        end
      end
      swtmr_pkg::OP_SLEEP: begin
        if (slot_mode_q[idx] == swtmr_pkg::MODE_FREE ||
            slot_mode_q[idx] == swtmr_pkg::MODE_SLEEP) begin
          err = 1'b1;
        end else begin
          slot_ticks_q[idx] = '0;
          slot_mode_q[idx]  = swtmr_pkg::MODE_SLEEP;
        end
      end
      swtmr_pkg::OP_WAKEUP: begin
        if (slot_mode_q[idx] != swtmr_pkg::MODE_SLEEP) begin
          err = 1'b1;
        end else begin
          slot_ticks_q[idx] = '0;
          slot_mode_q[idx]  = swtmr_pkg::MODE_READY;
        end
      end
      swtmr_pkg::OP_DELETE: begin
        if (slot_mode_q[idx] == swtmr_pkg::MODE_FREE) begin
          err = 1'b1;
        end else begin
          slot_mode_q[idx]   = swtmr_pkg::MODE_FREE;
          slot_ticks_q[idx]  = '0;
          slot_period_q[idx] = '0;
        end
      end
      default: err = 1'b1;
    endcase
    push_result(err, slot_out, 1'b0, 1'b1);
  endfunction

  // Drives one operation beat, holds it until accepted, then predicts it
  task automatic send_timer_op(logic [swtmr_pkg::OP_W-1:0] op, logic [2:0] idx,
                               logic [15:0] ticks, logic [15:0] reload);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {5'b0, reload, ticks, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_timer_op(op, idx, ticks, reload);
  endtask

  // Sender holds off until every expected beat has been seen
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    timer_result_t exp_r;
    timer_result_t act_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      act_r.status = m_axis_tdata_o[0];
      act_r.slot   = m_axis_tdata_o[3:1];
      act_r.fired  = m_axis_tuser_o[0];
      act_r.last   = m_axis_tlast_o;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("%0t unexpected beat: expected none, actual %b", $time, act_r);
      end else begin
        exp_r = expected_results.pop_front();
        if (act_r !== exp_r) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            if (act_r.status !== exp_r.status)
              $display("%0t status: expected %0d actual %0d", $time, exp_r.status,
                       act_r.status);
            if (act_r.slot !== exp_r.slot)
              $display("%0t result_slot: expected %0d actual %0d", $time, exp_r.slot,
                       act_r.slot);
            if (act_r.fired !== exp_r.fired)
              $display("%0t fired: expected %0d actual %0d", $time, exp_r.fired,
                       act_r.fired);
            if (act_r.last !== exp_r.last)
              $display("%0t last: expected %0d actual %0d", $time, exp_r.last,
                       act_r.last);
          end
        end
      end
    end
  end

  // Error paths on an empty table, filling it, a full dispatch and state changes
  task automatic test_directed_ops();
    send_timer_op(swtmr_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_DELAY, 3'd3, 16'd7, 16'd0);
    send_timer_op(swtmr_pkg::OP_SLEEP, 3'd7, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_WAKEUP, 3'd0, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_DELETE, 3'd5, 16'd0, 16'd0);
    send_timer_op(OP_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF);
    send_timer_op(swtmr_pkg::OP_REGISTER, 3'd0, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_REGISTER, 3'd7, 16'hFFFF, 16'hFFFF);
    for (int i = 2; i < SLOTS; i++)
      send_timer_op(swtmr_pkg::OP_REGISTER, 3'd0, 16'd0, 16'd5);
    send_timer_op(swtmr_pkg::OP_REGISTER, 3'd0, 16'd1, 16'd1);   // table full
    send_timer_op(swtmr_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_SLEEP, 3'd1, 16'd0, 16'd0);      // waiting slot
    send_timer_op(swtmr_pkg::OP_SLEEP, 3'd1, 16'd0, 16'd0);      // already asleep
    send_timer_op(swtmr_pkg::OP_WAKEUP, 3'd1, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_WAKEUP, 3'd2, 16'd0, 16'd0);     // ready, not asleep
    send_timer_op(swtmr_pkg::OP_SLEEP, 3'd2, 16'd0, 16'd0);      // ready slot
    send_timer_op(swtmr_pkg::OP_WAKEUP, 3'd2, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0);   // all eight fire
    send_timer_op(swtmr_pkg::OP_DELAY, 3'd1, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_DELETE, 3'd7, 16'd0, 16'd0);
    send_timer_op(swtmr_pkg::OP_REGISTER, 3'd0, 16'd2, 16'd0);
  endtask

  task automatic test_random_timer_traffic(int count);
    int                         pick;
    logic [swtmr_pkg::OP_W-1:0] op;
    logic [2:0]                 idx;
    logic [15:0]                ticks;
    logic [15:0]                reload;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 20) op = swtmr_pkg::OP_REGISTER;
      else if (pick < 50) op = swtmr_pkg::OP_TICK;
      else if (pick < 70) op = swtmr_pkg::OP_DISPATCH;
      else if (pick < 78) op = swtmr_pkg::OP_DELAY;
      else if (pick < 85) op = swtmr_pkg::OP_SLEEP;
      else if (pick < 92) op = swtmr_pkg::OP_WAKEUP;
      else if (pick < 98) op = swtmr_pkg::OP_DELETE;
      else op = OP_UNUSED;
      // mostly aim at occupied slots so state changes actually happen
      idx = 3'($urandom_range(7));
      if ($urandom_range(99) < 70)
        repeat (4) if (slot_mode_q[idx] == swtmr_pkg::MODE_FREE) idx = 3'($urandom_range(7));
      ticks = ($urandom_range(99) < 80) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 40) reload = '0;
      else if (pick < 85) reload = 16'($urandom_range(4, 1));
      else reload = 16'($urandom_range(65535));
      send_timer_op(op, idx, ticks, reload);
    end
  endtask

  initial begin
    reset_slot_table();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    wait_results_drained();

    src_idle_pct  = 35;
    sink_idle_pct = 62;
    test_random_timer_traffic(155);
    wait_results_drained();

    src_idle_pct  = 62;
    sink_idle_pct = 35;
    test_random_timer_traffic(155);
    wait_results_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_timer_traffic(160);
    wait_results_drained();

    repeat (SLOTS + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/swtmr_pkg.sv
hdl/swtmr_ctrl.sv
hdl/swtmr_dp.sv
hdl/software_timer_task_table.sv
sim/software_timer_task_table_tb.sv
